@@ hdl/uetr_pkg.sv @@
package uetr_pkg;

  // Receive FIFO geometry
  localparam int FIFO_DEPTH = 256;
  localparam int AW         = $clog2(FIFO_DEPTH);

  // Bit timing
  localparam int TIME_W   = 16;
  localparam int MAX_BITS = 10;
  localparam int ROUND_UP = 2;
  localparam int DROP_MAX = 65535;

  // Command codes
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Byte handed from the bit engine to the FIFO
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } push_t;

  // FIFO status seen by the top level
  typedef struct packed {
    logic [AW-1:0] fill;
    logic [15:0]   drops;
  } fifo_stat_t;

  // One result item
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        rx_valid;
    logic [7:0]  fill_count;
    logic [15:0] overflow_count;
  } result_t;

endpackage

@@ hdl/uetr_if.sv @@
// Edge / read command channel
interface uetr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] edge_time;
  logic        line_level;

  modport source (output valid, command, edge_time, line_level, input ready);
  modport sink   (input valid, command, edge_time, line_level, output ready);
endinterface

// Result channel
interface uetr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        rx_valid;
  logic [7:0]  fill_count;
  logic [15:0] overflow_count;

  modport source (output valid, rx_byte, rx_valid, fill_count, overflow_count, input ready);
  modport sink   (input valid, rx_byte, rx_valid, fill_count, overflow_count, output ready);
endinterface

@@ hdl/uetr_bit_engine.sv @@
module uetr_bit_engine import uetr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] edge_time,
  input  logic              line_level,
  output logic              done,
  output push_t             push
);

  // Phase codes, two's complement: idle, awaiting start, data bits 0..7
  localparam logic [3:0] PHASE_IDLE  = 4'b1110;
  localparam logic [3:0] PHASE_START = 4'b1111;
  localparam logic [3:0] PHASE_LAST  = 4'd7;

  typedef enum logic [1:0] {E_IDLE, E_SETUP, E_SHIFT} eng_state_t;

  eng_state_t        state_r, state_nxt;
  logic [3:0]        phase_r, phase_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              held_r, held_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              lvl_r, lvl_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              long_r, long_nxt;
  logic              done_r, done_nxt;
  push_t             push_r, push_nxt;

  logic [TIME_W-1:0] diff;
  logic [TIME_W:0]   diff_rnd;
  logic [TIME_W-3:0] nbits;

  // Interval in bits, rounded; timer wraps modulo 2^16
  assign diff     = now_r - prev_r;
  assign diff_rnd = {1'b0, diff} + (TIME_W+1)'(ROUND_UP);
  assign nbits    = diff_rnd[TIME_W:3];

  // One bit per cycle through the shift register
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    held_nxt      = held_r;
    prev_nxt      = prev_r;
    now_nxt       = now_r;
    lvl_nxt       = lvl_r;
    cnt_nxt       = cnt_r;
    long_nxt      = long_r;
    done_nxt      = 1'b0;
    push_nxt.valid = 1'b0;
    push_nxt.data  = {held_r, shift_r[7:1]};
    case (state_r)
      E_IDLE: begin
        if (start) begin
          now_nxt   = edge_time;
          lvl_nxt   = line_level;
          state_nxt = E_SETUP;
        end
      end
      E_SETUP: begin
        long_nxt = (nbits > (TIME_W-2)'(MAX_BITS));
        cnt_nxt  = long_nxt ? 4'(MAX_BITS) : nbits[3:0];
        // low line while idle: start bit
        if (phase_r == PHASE_IDLE && !held_r) begin
          phase_nxt = PHASE_START;
          shift_nxt = '0;
        end
        state_nxt = E_SHIFT;
      end
      E_SHIFT: begin
        if (cnt_r == '0 || phase_r == PHASE_IDLE) begin
          if (long_r) phase_nxt = PHASE_IDLE;
          held_nxt  = lvl_r;
          prev_nxt  = now_r;
          done_nxt  = 1'b1;
          state_nxt = E_IDLE;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
          if (!phase_r[3]) shift_nxt = {held_r, shift_r[7:1]};
          if (phase_r == PHASE_LAST) begin
            // last data bit reached: hand byte to the FIFO
            push_nxt.valid = 1'b1;
            phase_nxt      = PHASE_IDLE;
          end else begin
            phase_nxt = phase_r + 4'd1;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= E_IDLE;
      phase_r      <= PHASE_START;
      shift_r      <= '0;
      held_r       <= 1'b0;
      prev_r       <= '0;
      done_r       <= 1'b0;
      push_r.valid <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      held_r       <= held_nxt;
      prev_r       <= prev_nxt;
      done_r       <= done_nxt;
      push_r.valid <= push_nxt.valid;
    end
    now_r       <= now_nxt;
    lvl_r       <= lvl_nxt;
    cnt_r       <= cnt_nxt;
    long_r      <= long_nxt;
    push_r.data <= push_nxt.data;
  end

  assign done = done_r;
  assign push = push_r;

endmodule

@@ hdl/uetr_fifo.sv @@
module uetr_fifo import uetr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       pop,
  output logic       rd_ack,
  output logic       rd_hit,
  output logic [7:0] rd_data,
  output fifo_stat_t stat
);

  localparam logic [AW-1:0] FULL_LEVEL = AW'(FIFO_DEPTH - 2);
  localparam logic [AW-1:0] LAST_IDX   = AW'(FIFO_DEPTH - 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [15:0]   drops_r;
  logic          ack_r, hit_r;
  logic [7:0]    data_r;
  logic [AW-1:0] fill;
  logic          full, empty;

  // Occupancy, ring arithmetic valid for any depth
  always_comb begin
    if (wr_r >= rd_r) fill = wr_r - rd_r;
    else fill = AW'((AW+1)'(wr_r) + (AW+1)'(FIFO_DEPTH) - (AW+1)'(rd_r));
  end
  assign full  = (fill >= FULL_LEVEL);
  assign empty = (wr_r == rd_r);

  // Storage write
  always_ff @(posedge clk) begin
    if (push.valid && !full) mem[wr_r] <= push.data;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (pop && !empty) data_r <= mem[rd_r];
  end

  // Indices, drop counter, read handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      drops_r <= '0;
      ack_r   <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      ack_r <= pop;
      hit_r <= pop && !empty;
      if (push.valid) begin
        if (full) begin
          if (drops_r != 16'(DROP_MAX)) drops_r <= drops_r + 16'd1;
        end else begin
          wr_r <= (wr_r == LAST_IDX) ? '0 : wr_r + AW'(1);
        end
      end
      if (pop && !empty) rd_r <= (rd_r == LAST_IDX) ? '0 : rd_r + AW'(1);
    end
  end

  assign rd_ack     = ack_r;
  assign rd_hit     = hit_r;
  assign rd_data    = data_r;
  assign stat.fill  = fill;
  assign stat.drops = drops_r;

endmodule

@@ hdl/edge_timed_uart_receiver.sv @@
// Channel  Dir  Fields                                            Accepted when
// in_ch    in   command, edge_time[15:0], line_level              valid && ready
// out_ch   out  rx_byte[7:0], rx_valid, fill_count[7:0],
//               overflow_count[15:0]                              valid && ready
//
// One item at a time. An edge item runs through the bit engine, which takes
// 0..10 bits, one bit per cycle, and its status goes to the result register.
// A read item goes through the registered FIFO read to the result register.
// Synchronous active-low reset; the FIFO store itself is not cleared.
// A new item is taken while a result waits in the output register; a stalled
// output holds the next result in a staging register.
module edge_timed_uart_receiver import uetr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  uetr_in_if.sink   in_ch,
  uetr_out_if.source out_ch
);

  typedef enum logic [1:0] {T_IDLE, T_EDGE, T_READ, T_SEND} top_state_t;

  top_state_t state_r, state_nxt;
  result_t    res_r, res_nxt;
  result_t    out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       accept, eng_start, pop;
  logic       eng_done, rd_ack, rd_hit;
  logic [7:0] rd_data;
  push_t      push;
  fifo_stat_t stat;

  assign in_ch.ready = (state_r == T_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign eng_start   = accept && (in_ch.command == CMD_EDGE);
  assign pop         = accept && (in_ch.command == CMD_READ);

  uetr_bit_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (eng_start),
    .edge_time  (in_ch.edge_time),
    .line_level (in_ch.line_level),
    .done       (eng_done),
    .push       (push)
  );

  uetr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .rd_ack  (rd_ack),
    .rd_hit  (rd_hit),
    .rd_data (rd_data),
    .stat    (stat)
  );

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      T_IDLE: begin
        if (eng_start) state_nxt = T_EDGE;
        else if (pop) state_nxt = T_READ;
      end
      T_EDGE: begin
        if (eng_done) begin
          res_nxt.rx_byte        = '0;
          res_nxt.rx_valid       = 1'b0;
          res_nxt.fill_count     = 8'(stat.fill);
          res_nxt.overflow_count = stat.drops;
          state_nxt              = T_SEND;
        end
      end
      T_READ: begin
        if (rd_ack) begin
          res_nxt.rx_byte        = rd_hit ? rd_data : 8'd0;
          res_nxt.rx_valid       = rd_hit;
          res_nxt.fill_count     = 8'(stat.fill);
          res_nxt.overflow_count = stat.drops;
          state_nxt              = T_SEND;
        end
      end
      T_SEND: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.rx_byte        = out_r.rx_byte;
  assign out_ch.rx_valid       = out_r.rx_valid;
  assign out_ch.fill_count     = out_r.fill_count;
  assign out_ch.overflow_count = out_r.overflow_count;

endmodule

@@ hdl/uetr_checker.sv @@
module uetr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  rx_byte,
  input logic        rx_valid,
  input logic [7:0]  fill_count,
  input logic [15:0] overflow_count
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(rx_valid)
      && $stable(fill_count) && $stable(overflow_count))
    else $error("result changed while stalled");

  // Edge items and empty reads return a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !rx_valid |-> rx_byte == 8'd0)
    else $error("nonzero byte without rx_valid");

  // Drop counter only grows
  a_drops_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) && !$stable(overflow_count)
      |-> overflow_count > $past(overflow_count))
    else $error("overflow count went down");

  // One item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind edge_timed_uart_receiver uetr_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .rx_byte        (out_ch.rx_byte),
  .rx_valid       (out_ch.rx_valid),
  .fill_count     (out_ch.fill_count),
  .overflow_count (out_ch.overflow_count)
);
